### rtl/pot_pkg.sv
// ---------------------------------------------------------------------------
// pot_pkg: shared types and constants of the perceptron trainer
// Fixed point widths, configuration register indexes and the control
// and result structs passed between the lanes, the merge stage and the top.
// ---------------------------------------------------------------------------
package pot_pkg;

  // Fixed point widths
  localparam int unsigned FEAT_W  = 16;  // feature, Q8.8
  localparam int unsigned WGT_W   = 32;  // weight and bias, Q16.16
  localparam int unsigned RATE_W  = 16;  // learning rate, Q0.16
  localparam int unsigned FIU_W   = 4;   // features_in_use register
  localparam int unsigned PROD_W  = WGT_W + FEAT_W;  // exact w*x, Q24.24
  localparam int unsigned STEP_W  = RATE_W + 2 + FEAT_W;  // +/-rate * x
  localparam int unsigned DELTA_W = STEP_W - 8;  // weight step, Q10.16
  localparam int unsigned ACC_W   = PROD_W + 4;  // sum of products and bias

  // Stream packing
  localparam int unsigned IN_LANES   = 8;
  localparam int unsigned IN_DATA_W  = IN_LANES * FEAT_W;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = WGT_W;
  localparam int unsigned OUT_USER_W = 2;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FEATURES_IN_USE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [RATE_W-1:0] LEARNING_RATE_RST   = 16'd6554;
  localparam logic [FIU_W-1:0]  FEATURES_IN_USE_RST = 4'd2;

  // Per-lane strobes
  typedef struct packed {
    logic load;    // capture products of a new request
    logic update;  // apply the registered weight step
  } lane_ctl_t;

  // Outcome of the merge stage
  typedef struct packed {
    logic                    class_positive;
    logic                    misclassified;
    logic signed [WGT_W-1:0] score;
  } decision_t;

endpackage

### rtl/pot_lane.sv
// ---------------------------------------------------------------------------
// pot_lane: one feature lane
// Holds one weight, forms the exact product w*x and the signed weight step
// floor(+/-rate*x/256) for a new request, and applies the step with
// saturation when the merge stage reports a misclassified training sample.
// ---------------------------------------------------------------------------
module pot_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pot_pkg::lane_ctl_t                ctl_i,
  input  logic                              enable_i,
  input  logic                              label_positive_i,
  input  logic        [pot_pkg::RATE_W-1:0] learning_rate_i,
  input  logic signed [pot_pkg::FEAT_W-1:0] feature_i,
  output logic signed [pot_pkg::PROD_W-1:0] product_o
);
  import pot_pkg::*;

  logic signed [WGT_W-1:0]   weight_q, weight_d;
  logic signed [PROD_W-1:0]  product_q, product_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic signed [RATE_W+1:0]  rate_signed;
  logic signed [STEP_W-1:0]  step_prod;
  logic signed [WGT_W:0]     weight_sum;

  // Product and step for the incoming request; idle lanes contribute zero
  always_comb begin
    rate_signed = $signed({2'b00, learning_rate_i});
    if (!label_positive_i) begin
      rate_signed = -rate_signed;
    end
    step_prod = rate_signed * feature_i;
    product_d = enable_i ? PROD_W'(weight_q * feature_i) : '0;
    delta_d   = enable_i ? step_prod[STEP_W-1:8] : '0;
  end

  // Saturating weight update
  always_comb begin
    weight_sum = {weight_q[WGT_W-1], weight_q} + (WGT_W+1)'(delta_q);
    if (weight_sum[WGT_W] != weight_sum[WGT_W-1]) begin
      weight_d = weight_sum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}}
                                   : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      weight_d = weight_sum[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (ctl_i.update) begin
      weight_q <= weight_d;
    end
  end

  // Product and step registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      product_q <= product_d;
      delta_q   <= delta_d;
    end
  end

  assign product_o = product_q;

endmodule

### rtl/pot_merge.sv
// ---------------------------------------------------------------------------
// pot_merge: merge stage of the lanes
// Adds the lane products and the bias into an exact Q24.24 sum, rounds it
// down to Q16.16, saturates it to 32 bits and takes the class and the
// misclassification decision.
// ---------------------------------------------------------------------------
module pot_merge #(
  parameter int unsigned NumLanes = 8
) (
  input  logic signed [pot_pkg::PROD_W-1:0] product_i [NumLanes],
  input  logic signed [pot_pkg::WGT_W-1:0]  bias_i,
  input  logic                              train_i,
  input  logic                              label_positive_i,
  output pot_pkg::decision_t                decision_o
);
  import pot_pkg::*;

  localparam int unsigned SHR_W = ACC_W - 8;

  logic signed [ACC_W-1:0] acc;
  logic signed [SHR_W-1:0] acc_shr;
  logic signed [WGT_W-1:0] score;
  logic                    overflow;
  logic                    wrong;

  // Sum of the bias (moved to Q24.24) and all lane products
  always_comb begin
    acc = ACC_W'(bias_i) <<< 8;
    for (int unsigned j = 0; j < NumLanes; j++) begin
      acc = acc + ACC_W'(product_i[j]);
    end
  end

  // Round toward minus infinity, then saturate
  always_comb begin
    acc_shr  = acc[ACC_W-1:8];
    overflow = (acc_shr[SHR_W-1:WGT_W-1] != '0) && (acc_shr[SHR_W-1:WGT_W-1] != '1);
    if (overflow) begin
      score = acc_shr[SHR_W-1] ? {1'b1, {(WGT_W-1){1'b0}}}
                               : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      score = acc_shr[WGT_W-1:0];
    end
  end

  // label * score <= 0
  always_comb begin
    if (label_positive_i) begin
      wrong = (score <= 0);
    end else begin
      wrong = (score >= 0);
    end
  end

  assign decision_o.class_positive = (score > 0);
  assign decision_o.misclassified  = train_i && wrong;
  assign decision_o.score          = score;

endmodule

### rtl/perceptron_online_trainer.sv
// ---------------------------------------------------------------------------
// perceptron_online_trainer: fixed point perceptron with online training
// One request carries up to eight Q8.8 features, a predict/train flag and a
// label; the block answers with the class, the misclassified flag and the
// saturated Q16.16 score taken before any weight update.
// ---------------------------------------------------------------------------
// A new request is taken only once the previous one has left the weight
// loop: on acceptance every lane multiplies its weight by its feature into
// a register, then the merge stage sums the lanes with the bias, decides,
// and writes the updated weights and bias that the next request multiplies
// with. The input stays ready while a result waits in the output register;
// a waiting result holds the merge step. Configuration writes are taken in
// every cycle.
module perceptron_online_trainer #(
  parameter int unsigned MAX_FEATURES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample requests
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // feature_0 [15:0], feature_1 [31:16], ... feature_7 [127:112]
  input  logic [pot_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // func [0], label_positive [1]
  input  logic [pot_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  // Results
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // score [31:0]
  output logic [pot_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // class_positive [0], misclassified [1]
  output logic [pot_pkg::OUT_USER_W-1:0]     m_axis_tuser_o,
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pot_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [pot_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pot_pkg::*;

  logic [RATE_W-1:0]       learning_rate_q;
  logic [FIU_W-1:0]        features_in_use_q;
  logic                    busy_q;
  logic                    train_q;
  logic                    label_q;
  logic signed [WGT_W-1:0] bias_q, bias_d;
  logic signed [WGT_W:0]   bias_sum;
  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic [OUT_USER_W-1:0]   out_user_q;

  logic                    accept;
  logic                    advance;
  lane_ctl_t               lane_ctl;
  decision_t               decision;
  logic signed [PROD_W-1:0] products [MAX_FEATURES];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q   <= LEARNING_RATE_RST;
      features_in_use_q <= FEATURES_IN_USE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_LEARNING_RATE:   learning_rate_q   <= cfg_data_i[RATE_W-1:0];
        REG_FEATURES_IN_USE: features_in_use_q <= cfg_data_i[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: one request in flight through the weight loop
  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = busy_q && (!out_valid_q || m_axis_tready_i);

  assign lane_ctl.load   = accept;
  assign lane_ctl.update = advance && decision.misclassified;

  // Feature lanes; lane 0 always takes part
  for (genvar j = 0; j < MAX_FEATURES; j++) begin : g_lane
    logic lane_en;
    assign lane_en = (j == 0) || (FIU_W'(j) < features_in_use_q);

    pot_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .ctl_i            (lane_ctl),
      .enable_i         (lane_en),
      .label_positive_i (s_axis_tuser_i[1]),
      .learning_rate_i  (learning_rate_q),
      .feature_i        ($signed(s_axis_tdata_i[j*FEAT_W +: FEAT_W])),
      .product_o        (products[j])
    );
  end

  pot_merge #(
    .NumLanes (MAX_FEATURES)
  ) u_merge (
    .product_i        (products),
    .bias_i           (bias_q),
    .train_i          (train_q),
    .label_positive_i (label_q),
    .decision_o       (decision)
  );

  // Saturating bias update by +/- learning rate
  always_comb begin
    if (label_q) begin
      bias_sum = {bias_q[WGT_W-1], bias_q} + (WGT_W+1)'(learning_rate_q);
    end else begin
      bias_sum = {bias_q[WGT_W-1], bias_q} - (WGT_W+1)'(learning_rate_q);
    end
    if (bias_sum[WGT_W] != bias_sum[WGT_W-1]) begin
      bias_d = bias_sum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}}
                               : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      bias_d = bias_sum[WGT_W-1:0];
    end
  end

  // Control state, bias and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      bias_q      <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (advance) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (lane_ctl.update) begin
        bias_q <= bias_d;
      end
    end
  end

  // Request flags and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      train_q <= s_axis_tuser_i[0];
      label_q <= s_axis_tuser_i[1];
    end
    if (advance) begin
      out_data_q <= decision.score;
      out_user_q <= {decision.misclassified, decision.class_positive};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Assertions
  a_no_back_to_back_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> !accept
  ) else $error("request accepted while the weight loop was busy");

  a_class_matches_score: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == ($signed(m_axis_tdata_o) > 0))
  ) else $error("class flag disagrees with score");

  a_bias_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(advance && decision.misclassified) |=> $stable(bias_q)
  ) else $error("bias changed without a misclassified training sample");

  a_accept_starts_loop: assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> busy_q
  ) else $error("accepted request not held in the weight loop");

endmodule
